### design/phv_pkg.sv
package phv_pkg;

	typedef struct packed {
		logic [31:0] vertex_x;
		logic [31:0] vertex_y;
		logic [31:0] vertex_z;
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
	} phv_vertex_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} phv_color_t;

	typedef enum logic [2:0] {
		REG_LIGHT_X  = 3'd0,
		REG_LIGHT_Y  = 3'd1,
		REG_LIGHT_Z  = 3'd2,
		REG_VIEW_X   = 3'd3,
		REG_VIEW_Y   = 3'd4,
		REG_VIEW_Z   = 3'd5,
		REG_MATERIAL = 3'd6,
		REG_SHINE    = 3'd7
	} phv_reg_e;

	localparam int AMBIENT_Q8  = 51;
	localparam int DIFFUSE_Q8  = 256;
	localparam int SPECULAR_Q8 = 256;

	localparam int EXP_W      = 8;
	localparam int PWR_STAGES = (1 << EXP_W) - 1;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	// Clamp a Q2.30 dot product to 0..1.0 and return it as Q1.15.
	function automatic logic [15:0] clamp_q15(input logic signed [43:0] dv);
		logic [15:0] res;
		if (dv < 0) begin
			res = 16'd0;
		end else if (dv > 44'sd1073741824) begin
			res = ONE_Q15;
		end else begin
			res = dv[30:15];
		end
		return res;
	endfunction

endpackage

### design/phv_unitize.sv
module phv_unitize import phv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [2:0][32:0]  vec,
	output logic              valid_out,
	output logic [2:0][16:0]  unit
);

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][29:0] mag;
	} carry_t;

	logic [2:0]        neg_s1;
	logic [2:0][31:0]  mag_s1;
	logic              v_s1, v_s2, v_s3;
	carry_t            c_s2, c_s3;
	logic [2:0][59:0]  sqr_s3;

	logic [62:0] sq_x_s [SQ_STEPS+1];
	logic [62:0] sq_r_s [SQ_STEPS+1];
	carry_t      sq_c_s [SQ_STEPS+1];
	logic        sq_v_s [SQ_STEPS+1];

	logic [2:0][31:0] dv_rem_s [DIV_STEPS+1];
	logic [2:0][15:0] dv_q_s   [DIV_STEPS+1];
	logic [30:0]      dv_len_s [DIV_STEPS+1];
	carry_t           dv_c_s   [DIV_STEPS+1];
	logic             dv_v_s   [DIV_STEPS+1];

	logic [1:0] shamt;

	always_comb begin
		if (mag_s1[0][31] | mag_s1[1][31] | mag_s1[2][31]) begin
			shamt = 2'd2;
		end else if (mag_s1[0][30] | mag_s1[1][30] | mag_s1[2][30]) begin
			shamt = 2'd1;
		end else begin
			shamt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1      <= valid_in;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			sq_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i]     <= vec[i][32];
				mag_s1[i]     <= vec[i][32] ? 32'(~vec[i] + 33'd1) : vec[i][31:0];
				c_s2.mag[i]   <= 30'(mag_s1[i] >> shamt);
				sqr_s3[i]     <= 60'(c_s2.mag[i] * c_s2.mag[i]);
			end
			c_s2.neg  <= neg_s1;
			c_s3      <= c_s2;
			sq_x_s[0] <= 63'(sqr_s3[0]) + 63'(sqr_s3[1]) + 63'(sqr_s3[2]);
			sq_r_s[0] <= '0;
			sq_c_s[0] <= c_s3;
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = {1'b0, sq_r_s[k]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, sq_x_s[k]} >= trial) begin
					sq_x_s[k+1] <= sq_x_s[k] - trial[62:0];
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + BIT;
				end else begin
					sq_x_s[k+1] <= sq_x_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_c_s[k+1] <= sq_c_s[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] = 32'(sq_c_s[SQ_STEPS].mag[i]);
		end
		dv_q_s[0]   = '0;
		dv_len_s[0] = sq_r_s[SQ_STEPS][30:0];
		dv_c_s[0]   = sq_c_s[SQ_STEPS];
		dv_v_s[0]   = sq_v_s[SQ_STEPS];
	end

	// Restoring division of mag * 2^15 by the length, one quotient bit per stage.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [2:0][31:0] shifted;
		logic [2:0]       qbit;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				shifted[i] = (j == 0) ? dv_rem_s[j][i] : (dv_rem_s[j][i] << 1);
				qbit[i]    = shifted[i] >= 32'(dv_len_s[j]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j+1][i] <= qbit[i] ? shifted[i] - 32'(dv_len_s[j]) : shifted[i];
					dv_q_s[j+1][i]   <= {dv_q_s[j][i][14:0], qbit[i]};
				end
				dv_len_s[j+1] <= dv_len_s[j];
				dv_c_s[j+1]   <= dv_c_s[j];
			end
		end
	end

	// A zero vector has zero length and normalizes to zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_len_s[DIV_STEPS] == '0) begin
				unit[i] = '0;
			end else if (dv_c_s[DIV_STEPS].neg[i]) begin
				unit[i] = 17'(~{1'b0, dv_q_s[DIV_STEPS][i]} + 17'd1);
			end else begin
				unit[i] = {1'b0, dv_q_s[DIV_STEPS][i]};
			end
		end
	end

	assign valid_out = dv_v_s[DIV_STEPS];

endmodule

### design/phv_shade.sv
module phv_shade import phv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [2:0][16:0] n,
	input  logic [2:0][16:0] l,
	input  logic [2:0][16:0] v,
	output logic             valid_out,
	output logic [15:0]      diffuse,
	output logic [15:0]      base
);

	logic [2:0][16:0] n_s1, l_s1, v_s1, n_s2, l_s2, v_s2, l_s3, v_s3, v_s4;
	logic [2:0][33:0] nl_s1;
	logic [35:0]      dnl_s2;
	logic [2:0][52:0] m_s3;
	logic [2:0][24:0] r_s4;
	logic [2:0][41:0] vr_s5;
	logic [15:0]      d_s3, d_s4, d_s5, d_s6;
	logic [15:0]      x_s6;
	logic             vl_s1, vl_s2, vl_s3, vl_s4, vl_s5, vl_s6;

	logic signed [53:0] twice  [3];
	logic signed [53:0] biased [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			twice[i]  = {$signed(m_s3[i]), 1'b0};
			// Division by 2^30 rounds toward zero.
			biased[i] = twice[i] + (twice[i][53] ? 54'sd1073741823 : 54'sd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_s1 <= 1'b0;
			vl_s2 <= 1'b0;
			vl_s3 <= 1'b0;
			vl_s4 <= 1'b0;
			vl_s5 <= 1'b0;
			vl_s6 <= 1'b0;
		end else if (en) begin
			vl_s1 <= valid_in;
			vl_s2 <= vl_s1;
			vl_s3 <= vl_s2;
			vl_s4 <= vl_s3;
			vl_s5 <= vl_s4;
			vl_s6 <= vl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nl_s1[i] <= 34'($signed(n[i]) * $signed(l[i]));
				m_s3[i]  <= 53'($signed(dnl_s2) * $signed(n_s2[i]));
				r_s4[i]  <= 25'($signed(biased[i][53:30])) - 25'($signed(l_s3[i]));
				vr_s5[i] <= 42'($signed(v_s4[i]) * $signed(r_s4[i]));
			end
			n_s1 <= n;
			l_s1 <= l;
			v_s1 <= v;
			n_s2 <= n_s1;
			l_s2 <= l_s1;
			v_s2 <= v_s1;
			dnl_s2 <= 36'($signed(nl_s1[0])) + 36'($signed(nl_s1[1]))
				+ 36'($signed(nl_s1[2]));
			l_s3 <= l_s2;
			v_s3 <= v_s2;
			d_s3 <= clamp_q15(44'($signed(dnl_s2)));
			v_s4 <= v_s3;
			d_s4 <= d_s3;
			d_s5 <= d_s4;
			d_s6 <= d_s5;
			x_s6 <= clamp_q15(44'($signed(vr_s5[0])) + 44'($signed(vr_s5[1]))
				+ 44'($signed(vr_s5[2])));
		end
	end

	assign valid_out = vl_s6;
	assign diffuse   = d_s6;
	assign base      = x_s6;

endmodule

### design/phv_power.sv
module phv_power import phv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [EXP_W-1:0] shine,
	input  logic [15:0]      base,
	input  logic [15:0]      diffuse,
	output logic             valid_out,
	output logic [15:0]      power,
	output logic [15:0]      diffuse_out
);

	logic [15:0] p_s [PWR_STAGES+1];
	logic [15:0] x_s [PWR_STAGES+1];
	logic [15:0] d_s [PWR_STAGES+1];
	logic        v_s [PWR_STAGES+1];

	assign p_s[0] = ONE_Q15;
	assign x_s[0] = base;
	assign d_s[0] = diffuse;
	assign v_s[0] = valid_in;

	// Stage k applies one multiplication while k is below the exponent.
	for (genvar k = 0; k < PWR_STAGES; k++) begin : g_pow
		logic [31:0] prod;
		assign prod = p_s[k] * x_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k+1] <= (EXP_W'(k) < shine) ? prod[30:15] : p_s[k];
				x_s[k+1] <= x_s[k];
				d_s[k+1] <= d_s[k];
			end
		end
	end

	assign valid_out   = v_s[PWR_STAGES];
	assign power       = p_s[PWR_STAGES];
	assign diffuse_out = d_s[PWR_STAGES];

endmodule

### design/phong_vertex_lighting_unit.sv
// Channel  Payload        Handshake
// vertex   phv_vertex_t   vertex_valid / vertex_stall
// color    phv_color_t    color_valid / color_stall
// config   cfg_data       cfg_write, cfg_index (write only)
//
// One vertex is taken every cycle unless a colour beat is stalled. The path
// to the colour beat: 1 input stage, 52 in normalization (4 setup, 32 square
// root, 16 divide), 6 in the dot products, 255 in the exponent chain, 1 out.
// The exponent chain of one multiplier per stage sets the depth.
// Reset clears the valid bits and loads the register defaults.
// A stalled colour beat freezes the whole pipeline; nothing is lost.
module phong_vertex_lighting_unit import phv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vertex_valid,
	output logic        vertex_stall,
	input  phv_vertex_t vertex,
	output logic        color_valid,
	input  logic        color_stall,
	output phv_color_t  color,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [2:0][31:0] light_q, view_q;
	logic [23:0]      material_q;
	logic [EXP_W-1:0] shine_q;

	logic             en;
	logic             v_s1;
	logic [2:0][32:0] ld_s1, vd_s1, nd_s1;

	logic             un_v, ul_v, uv_v;
	logic [2:0][16:0] un, ul, uv;
	logic             sh_v;
	logic [15:0]      sh_d, sh_x;
	logic             pw_v;
	logic [15:0]      pw_p, pw_d;

	logic [2:0][7:0]  mat;
	logic [2:0][7:0]  chan;
	logic             out_v_q;
	phv_color_t       out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q    <= '0;
			view_q     <= '0;
			material_q <= 24'h8DCAEF;
			shine_q    <= EXP_W'(8);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LIGHT_X:  light_q[0] <= cfg_data;
				REG_LIGHT_Y:  light_q[1] <= cfg_data;
				REG_LIGHT_Z:  light_q[2] <= cfg_data;
				REG_VIEW_X:   view_q[0]  <= cfg_data;
				REG_VIEW_Y:   view_q[1]  <= cfg_data;
				REG_VIEW_Z:   view_q[2]  <= cfg_data;
				REG_MATERIAL: material_q <= cfg_data[23:0];
				REG_SHINE:    shine_q    <= cfg_data[EXP_W-1:0];
				default:      ;
			endcase
		end
	end

	assign en           = !out_v_q || !color_stall;
	assign vertex_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vertex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_s1[0] <= {light_q[0][31], light_q[0]} - {vertex.vertex_x[31], vertex.vertex_x};
			ld_s1[1] <= {light_q[1][31], light_q[1]} - {vertex.vertex_y[31], vertex.vertex_y};
			ld_s1[2] <= {light_q[2][31], light_q[2]} - {vertex.vertex_z[31], vertex.vertex_z};
			vd_s1[0] <= {view_q[0][31], view_q[0]} - {vertex.vertex_x[31], vertex.vertex_x};
			vd_s1[1] <= {view_q[1][31], view_q[1]} - {vertex.vertex_y[31], vertex.vertex_y};
			vd_s1[2] <= {view_q[2][31], view_q[2]} - {vertex.vertex_z[31], vertex.vertex_z};
			nd_s1[0] <= {{17{vertex.normal_x[15]}}, vertex.normal_x};
			nd_s1[1] <= {{17{vertex.normal_y[15]}}, vertex.normal_y};
			nd_s1[2] <= {{17{vertex.normal_z[15]}}, vertex.normal_z};
		end
	end

	phv_unitize u_norm_n (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v_s1), .vec(nd_s1),
		.valid_out(un_v), .unit(un)
	);

	phv_unitize u_norm_l (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v_s1), .vec(ld_s1),
		.valid_out(ul_v), .unit(ul)
	);

	phv_unitize u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v_s1), .vec(vd_s1),
		.valid_out(uv_v), .unit(uv)
	);

	phv_shade u_shade (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(un_v),
		.n(un), .l(ul), .v(uv),
		.valid_out(sh_v), .diffuse(sh_d), .base(sh_x)
	);

	phv_power u_power (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(sh_v), .shine(shine_q),
		.base(sh_x), .diffuse(sh_d),
		.valid_out(pw_v), .power(pw_p), .diffuse_out(pw_d)
	);

	assign mat[0] = material_q[23:16];
	assign mat[1] = material_q[15:8];
	assign mat[2] = material_q[7:0];

	always_comb begin
		logic [33:0] sum;
		for (int i = 0; i < 3; i++) begin
			sum = ((34'(mat[i]) * 34'(AMBIENT_Q8)) << 15)
				+ 34'(mat[i]) * 34'(DIFFUSE_Q8) * 34'(pw_d)
				+ 34'(255 * SPECULAR_Q8) * 34'(pw_p);
			chan[i] = (sum[33:23] > 11'd255) ? 8'd255 : sum[30:23];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= pw_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.red   <= chan[0];
			out_q.green <= chan[1];
			out_q.blue  <= chan[2];
		end
	end

	assign color_valid = out_v_q;
	assign color       = out_q;

	// The three normalizers must stay in lock step.
	a_norm_align: assert property (@(posedge clk) disable iff (!arst_n)
		(un_v == ul_v) && (ul_v == uv_v))
		else $error("normalizer valid bits out of step");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall == (color_valid && color_stall))
		else $error("input stall does not follow output back-pressure");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(color_valid && color_stall) |=> ($stable(pw_v) && $stable(pw_p)))
		else $error("exponent chain moved during a stalled beat");

endmodule

### test/tb.sv
module tb;
	import phv_pkg::*;

	localparam int LATENCY = 315;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        vertex_valid;
	logic        vertex_stall;
	phv_vertex_t vertex;
	logic        color_valid;
	logic        color_stall;
	phv_color_t  color;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	phong_vertex_lighting_unit uut (
		.clk(clk), .arst_n(arst_n),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
		.color_valid(color_valid), .color_stall(color_stall), .color(color),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the lighting registers.
	logic signed [31:0] light_pos [3];
	logic signed [31:0] eye_pos [3];
	logic [23:0] material;
	logic [7:0]  shininess;

	phv_color_t pending_colours [$];
	int errors;
	int idle_cycles;
	bit stall_mode;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Scale a vector to Q1.15 unit length by magnitude, then reapply signs.
	function automatic void to_unit(input longint vec [3], output longint unit_vec [3]);
		longint unsigned mag [3];
		longint unsigned biggest;
		longint unsigned sumsq;
		longint unsigned root;
		longint unsigned rbit;
		longint unsigned q;
		biggest = 0;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (vec[i] < 0) ? longint'(-vec[i]) : longint'(vec[i]);
			if (mag[i] > biggest) biggest = mag[i];
		end
		while (biggest >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
			biggest = biggest >> 1;
		end
		for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
		root = 0;
		rbit = 64'd1 << 62;
		while (rbit > sumsq) rbit = rbit >> 2;
		while (rbit != 0) begin
			if (sumsq >= root + rbit) begin
				sumsq -= root + rbit;
				root = (root >> 1) + rbit;
			end else begin
				root = root >> 1;
			end
			rbit = rbit >> 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = (root == 0) ? 0 : (mag[i] << 15) / root;
			unit_vec[i] = (vec[i] < 0) ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic longint unsigned clamp_dot(input longint dv);
		if (dv < 0) dv = 0;
		if (dv > (64'sd1 << 30)) dv = 64'sd1 << 30;
		return longint'(dv) >> 15;
	endfunction

	function automatic logic [7:0] shade(input longint unsigned m, input longint unsigned d,
			input longint unsigned s);
		longint unsigned acc;
		acc = m * AMBIENT_Q8 * 32768 + m * DIFFUSE_Q8 * d + 255 * SPECULAR_Q8 * s;
		acc = acc >> 23;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	function automatic phv_color_t light_vertex(input phv_vertex_t vx);
		longint pos [3], raw [3], vec [3], nrm [3], ldir [3], vdir [3], refl [3];
		longint ndotl, vdotr;
		longint unsigned diffuse, base, power;
		phv_color_t c;
		pos[0] = longint'(signed'(vx.vertex_x));
		pos[1] = longint'(signed'(vx.vertex_y));
		pos[2] = longint'(signed'(vx.vertex_z));
		raw[0] = longint'(signed'(vx.normal_x));
		raw[1] = longint'(signed'(vx.normal_y));
		raw[2] = longint'(signed'(vx.normal_z));
		to_unit(raw, nrm);
		for (int i = 0; i < 3; i++) vec[i] = longint'(light_pos[i]) - pos[i];
		to_unit(vec, ldir);
		for (int i = 0; i < 3; i++) vec[i] = longint'(eye_pos[i]) - pos[i];
		to_unit(vec, vdir);
		ndotl = nrm[0] * ldir[0] + nrm[1] * ldir[1] + nrm[2] * ldir[2];
		diffuse = clamp_dot(ndotl);
		for (int i = 0; i < 3; i++) refl[i] = -ldir[i] + (2 * ndotl * nrm[i]) / (64'sd1 << 30);
		vdotr = vdir[0] * refl[0] + vdir[1] * refl[1] + vdir[2] * refl[2];
		base = clamp_dot(vdotr);
		power = 32768;
		for (int e = 0; e < shininess; e++) power = (power * base) >> 15;
		c.red   = shade(material[23:16], diffuse, power);
		c.green = shade(material[15:8], diffuse, power);
		c.blue  = shade(material[7:0], diffuse, power);
		return c;
	endfunction

	task automatic write_reg(input phv_reg_e idx, input logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_LIGHT_X, REG_LIGHT_Y, REG_LIGHT_Z: light_pos[idx - REG_LIGHT_X] = val;
			REG_VIEW_X, REG_VIEW_Y, REG_VIEW_Z: eye_pos[idx - REG_VIEW_X] = val;
			REG_MATERIAL: material = val[23:0];
			REG_SHINE: shininess = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Drains the pipeline so registers are only changed while it is idle.
	task automatic drain();
		while (pending_colours.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// Presents one vertex and holds it until the beat is taken.
	task automatic send_vertex(input phv_vertex_t vx);
		vertex_valid <= 1'b1;
		vertex <= vx;
		do @(posedge clk); while (vertex_stall);
		pending_colours.push_back(light_vertex(vx));
		@(negedge clk);
	endtask

	task automatic pause_sender();
		vertex_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
		endcase
	endfunction

	function automatic phv_vertex_t rand_vertex();
		phv_vertex_t vx;
		vx.vertex_x = rand_pos();
		vx.vertex_y = rand_pos();
		vx.vertex_z = rand_pos();
		vx.normal_x = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		vx.normal_y = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		vx.normal_z = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		if ($urandom_range(0, 30) == 0) {vx.normal_x, vx.normal_y, vx.normal_z} = '0;
		return vx;
	endfunction

	task automatic random_phase(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && count > 0) begin
				send_vertex(rand_vertex());
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0) pause_sender();
		end
		vertex_valid <= 1'b0;
	endtask

	// Receiver stall pattern: alternates between free-running and choppy stretches.
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
		color_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && color_valid && !color_stall) begin
			if (pending_colours.size() == 0) begin
				$display("%0t: colour beat with none expected, actual %h", $time, color);
				errors++;
			end else begin
				phv_color_t want;
				want = pending_colours.pop_front();
				if (color.red !== want.red || color.green !== want.green
						|| color.blue !== want.blue) begin
					$display("%0t: colour expected %h actual %h", $time, want, color);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vertex_valid && !vertex_stall) || (color_valid && !color_stall)
				|| (pending_colours.size() == 0 && !vertex_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("phong_vertex_lighting_unit: mismatch");
			$finish;
		end
	end

	typedef struct {
		logic [31:0] vx, vy, vz;
		logic [15:0] nx, ny, nz;
		bit          known;
		logic [23:0] rgb;
	} vertex_row_t;

	vertex_row_t directed [] = '{
		// Everything at the origin: only ambient light remains.
		'{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 24'h1C282F},
		'{32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 1'b1, 24'h1C282F},
		'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 24'h0},
		'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, 24'h0},
		'{32'hFFFFFFFF, 32'h00000001, 32'h00010000, 16'hFFFF, 16'h0001, 16'h4000, 1'b0, 24'h0},
		'{32'hFFFF0000, 32'h0, 32'hFFFF0000, 16'h0, 16'hC000, 16'h4000, 1'b0, 24'h0},
		'{32'h00030000, 32'hFFFD0000, 32'h00050000, 16'h2D41, 16'h2D41, 16'h0, 1'b0, 24'h0},
		'{32'h0, 32'h0, 32'hFFF60000, 16'h0, 16'h0, 16'h4000, 1'b0, 24'h0}
	};

	task automatic run_directed();
		phv_color_t got_expect;
		foreach (directed[k]) begin
			if (directed[k].known) begin
				got_expect = light_vertex({directed[k].vx, directed[k].vy, directed[k].vz,
					directed[k].nx, directed[k].ny, directed[k].nz});
				if (got_expect !== phv_color_t'(directed[k].rgb)) begin
					$display("%0t: ambient row expected %h actual %h", $time,
						directed[k].rgb, got_expect);
					errors++;
				end
			end
			send_vertex({directed[k].vx, directed[k].vy, directed[k].vz,
				directed[k].nx, directed[k].ny, directed[k].nz});
		end
		vertex_valid <= 1'b0;
	endtask

	initial begin
		errors = 0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		vertex_valid = 1'b0;
		vertex = '0;
		color_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_LIGHT_X;
		cfg_data = '0;
		for (int i = 0; i < 3; i++) begin
			light_pos[i] = '0;
			eye_pos[i] = '0;
		end
		material = 24'h8DCAEF;
		shininess = 8'd8;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		drain();

		// Light and viewer on the z axis, so the specular highlight is reachable.
		write_reg(REG_LIGHT_X, 32'h00000000);
		write_reg(REG_LIGHT_Y, 32'h00000000);
		write_reg(REG_LIGHT_Z, 32'h000A0000);
		write_reg(REG_VIEW_X, 32'h00000000);
		write_reg(REG_VIEW_Y, 32'h00000000);
		write_reg(REG_VIEW_Z, 32'h000A0000);
		write_reg(REG_SHINE, 32'd1);
		send_vertex({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000});
		send_vertex({32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hC000});
		send_vertex({32'h0, 32'h0, 32'h000A0000, 16'h0, 16'h0, 16'h4000});
		vertex_valid <= 1'b0;
		random_phase(400);
		drain();

		write_reg(REG_SHINE, 32'd128);
		write_reg(REG_MATERIAL, 32'hFFFFFF);
		write_reg(REG_LIGHT_X, 32'h7FFFFFFF);
		write_reg(REG_VIEW_Y, 32'h80000000);
		random_phase(400);
		drain();

		write_reg(REG_SHINE, 32'd0);
		write_reg(REG_MATERIAL, 32'h000000);
		write_reg(REG_LIGHT_X, 32'h80000000);
		write_reg(REG_LIGHT_Y, 32'h7FFFFFFF);
		write_reg(REG_VIEW_Z, 32'hFFF00000);
		random_phase(400);
		drain();

		write_reg(REG_SHINE, 32'd255);
		write_reg(REG_MATERIAL, 32'h123456);
		write_reg(REG_LIGHT_Z, $urandom);
		write_reg(REG_VIEW_X, $urandom);
		random_phase(350);
		drain();

		write_reg(REG_SHINE, 32'($urandom_range(1, 32)));
		write_reg(REG_MATERIAL, 32'($urandom & 32'hFFFFFF));
		write_reg(REG_LIGHT_X, 32'h00050000);
		write_reg(REG_LIGHT_Y, 32'h00050000);
		write_reg(REG_LIGHT_Z, 32'h00050000);
		write_reg(REG_VIEW_X, 32'hFFFB0000);
		write_reg(REG_VIEW_Y, 32'h00050000);
		write_reg(REG_VIEW_Z, 32'h00050000);
		random_phase(390);

		drain();
		if (errors == 0)
			$display("phong_vertex_lighting_unit: match");
		else
			$display("phong_vertex_lighting_unit: mismatch");
		$finish;
	end

endmodule

### files.f
design/phv_pkg.sv
design/phv_unitize.sv
design/phv_shade.sv
design/phv_power.sv
design/phong_vertex_lighting_unit.sv
test/tb.sv
